### rtl/core/dsg_pkg.sv
`timescale 1ns / 1ps
// Shared constants, register map, config struct and sine table builder for the tone generator.
package dsg_pkg;

  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam int unsigned SAMPLE_BITS      = 16;

  // pi/2 in Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_PHASE_INC    = 2'd0,
    REG_AMPLITUDE    = 2'd1,
    REG_DECAY_FACTOR = 2'd2,
    REG_SAMPLE_COUNT = 2'd3
  } reg_idx_e;

  localparam logic [31:0] PHASE_INC_RST    = 32'd0;
  localparam logic [15:0] AMPLITUDE_RST    = 16'd32768;
  localparam logic [31:0] DECAY_FACTOR_RST = 32'h8000_0000;
  localparam logic [23:0] SAMPLE_COUNT_RST = 24'd44100;
  localparam logic [31:0] ENVELOPE_ONE     = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] phase_increment;
    logic [15:0] amplitude;
    logic [31:0] decay_factor;
    logic [23:0] sample_count;
  } cfg_t;

  // term * x^2 in Q2.30, truncating after each product
  function automatic logic [63:0] taylor_pow2(input logic [63:0] term, input logic [63:0] x);
    logic [63:0] t;
    t = (term * x) >> 30;
    t = (t * x) >> 30;
    return t;
  endfunction

  // sin(x) for x in Q2.30, nine Taylor terms, rounded half up to Q1.15 and capped at 1.0
  function automatic logic [15:0] sine_from_x(input logic [63:0] x);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] v;
    term = x;
    sum  = x;
    term = taylor_pow2(term, x) / 64'd6;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = taylor_pow2(term, x) / 64'd20;
    sum  = sum + term;
    term = taylor_pow2(term, x) / 64'd42;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = taylor_pow2(term, x) / 64'd72;
    sum  = sum + term;
    term = taylor_pow2(term, x) / 64'd110;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = taylor_pow2(term, x) / 64'd156;
    sum  = sum + term;
    term = taylor_pow2(term, x) / 64'd210;
    sum  = (sum >= term) ? sum - term : 64'd0;
    term = taylor_pow2(term, x) / 64'd272;
    sum  = sum + term;
    v = (sum + 64'd16384) >> 15;
    if (v > 64'd32768) begin
      v = 64'd32768;
    end
    return v[15:0];
  endfunction

endpackage

### rtl/core/dsg_mul.sv
`timescale 1ns / 1ps
// Shared 32x32 unsigned multiplier with registered product.
module dsg_mul (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] op_a_i,
  input  logic [31:0] op_b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_q;
  logic [63:0] prod_d;

  assign prod_d = 64'(op_a_i) * 64'(op_b_i);

  // hold the product while the sequencer stalls
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

### rtl/core/dsg_sine_rom.sv
`timescale 1ns / 1ps
// Quarter-wave sine ROM, Q1.15 entries built at elaboration, registered read.
module dsg_sine_rom #(
  parameter int unsigned Depth = dsg_pkg::SINE_TABLE_DEPTH,
  localparam int unsigned AddrW = $clog2(Depth + 1)
) (
  input  logic             clk_i,
  input  logic [AddrW-1:0] addr_i,
  output logic [15:0]      data_o
);

  logic [15:0] rom [0:Depth];
  logic [15:0] data_q;

  for (genvar k = 0; k <= Depth; k++) begin : g_entry
    localparam logic [63:0] AngleQ30 =
      (64'(k) * dsg_pkg::HALF_PI_Q30 + 64'(Depth / 2)) / 64'(Depth);
    assign rom[k] = dsg_pkg::sine_from_x(AngleQ30);
  end

  always_ff @(posedge clk_i) begin
    data_q <= rom[addr_i];
  end

  assign data_o = data_q;

endmodule

### rtl/core/dsg_regs.sv
`timescale 1ns / 1ps
// APB-style configuration register file for the tone generator.
module dsg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dsg_pkg::PADDR_W-1:0]  paddr,
  input  logic [dsg_pkg::PDATA_W-1:0]  pwdata,
  output logic [dsg_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output dsg_pkg::cfg_t                cfg_o
);

  dsg_pkg::cfg_t     cfg_q;
  dsg_pkg::reg_idx_e reg_idx;
  logic              wr_en;

  assign reg_idx = dsg_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_increment <= dsg_pkg::PHASE_INC_RST;
      cfg_q.amplitude       <= dsg_pkg::AMPLITUDE_RST;
      cfg_q.decay_factor    <= dsg_pkg::DECAY_FACTOR_RST;
      cfg_q.sample_count    <= dsg_pkg::SAMPLE_COUNT_RST;
    end else if (wr_en) begin
      case (reg_idx)
        dsg_pkg::REG_PHASE_INC:    cfg_q.phase_increment <= pwdata;
        dsg_pkg::REG_AMPLITUDE:    cfg_q.amplitude       <= pwdata[15:0];
        dsg_pkg::REG_DECAY_FACTOR: cfg_q.decay_factor    <= pwdata;
        dsg_pkg::REG_SAMPLE_COUNT: cfg_q.sample_count    <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dsg_pkg::REG_PHASE_INC:    prdata = cfg_q.phase_increment;
      dsg_pkg::REG_AMPLITUDE:    prdata = 32'(cfg_q.amplitude);
      dsg_pkg::REG_DECAY_FACTOR: prdata = cfg_q.decay_factor;
      dsg_pkg::REG_SAMPLE_COUNT: prdata = 32'(cfg_q.sample_count);
      default:                   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/decaying_sine_generator.sv
`timescale 1ns / 1ps
// Decaying sine tone generator: top level with sequencer around one shared multiplier.
// A tick that yields a sample runs the phase-to-index product, the registered sine ROM read,
// the amplitude, envelope and decay products through the single multiplier, and the commit
// step, in that order; restart and idle ticks complete in the accept cycle. No new tick is
// taken until the commit step is done; a stalled output holds the commit step and the next tick.
// Reset (rst_ni low, asynchronous): registers to defaults, note idle, no result pending.
module decaying_sine_generator #(
  parameter int unsigned SineTableDepth = dsg_pkg::SINE_TABLE_DEPTH,
  parameter int unsigned SampleBits     = dsg_pkg::SAMPLE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // APB-style configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dsg_pkg::PADDR_W-1:0]  paddr,
  input  logic [dsg_pkg::PDATA_W-1:0]  pwdata,
  output logic [dsg_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  // tick / restart beats
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         restart_i,
  // sample beats
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [15:0]           sample_o,
  output logic                         last_sample_o,
  output logic [15:0]                  peak_level_o
);

  localparam int unsigned AddrW = $clog2(SineTableDepth + 1);
  // two's complement width that holds the saturated sample and its low 16 bits
  localparam int unsigned ResW  = ((SampleBits > 16) ? SampleBits : 16) + 1;
  localparam logic [63:0] SampLimit = 64'(1) << (SampleBits - 1);
  localparam logic [63:0] SampRound = 64'(1) << (46 - SampleBits);
  localparam int unsigned SampShift = 47 - SampleBits;

  // one-hot sequencer
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,  // take a beat; start the phase-to-index product
    ST_ADDR = 6'b000010,  // fold the index into the quarter wave, read the ROM
    ST_AMP  = 6'b000100,  // table value times amplitude
    ST_ENV  = 6'b001000,  // rounded Q.15 magnitude times envelope
    ST_DEC  = 6'b010000,  // finish the sample; envelope times decay factor
    ST_UPD  = 6'b100000   // commit state and hand the sample to the output register
  } state_e;

  dsg_pkg::cfg_t cfg;

  state_e state_q, state_d;

  logic [31:0] phase_q;
  logic [31:0] env_q;
  logic [23:0] done_q;
  logic [15:0] peak_q;
  logic        active_q;
  logic        neg_q;      // quadrant sign of the sample in flight

  logic [15:0] res_sample_q;

  logic        out_valid_q;
  logic [15:0] out_sample_q;
  logic        out_last_q;
  logic [15:0] out_peak_q;

  logic        mul_en;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic [AddrW-1:0] k_idx;
  logic [AddrW-1:0] rom_addr;
  logic [15:0]      rom_data;

  logic [31:0]           amp_sum;
  logic [16:0]           amp_mag;
  logic [63:0]           samp_mag;
  logic [SampleBits-1:0] samp_sat;
  logic [ResW-1:0]       samp_ext;
  logic [ResW-1:0]       samp_res;
  logic [15:0]           peak_cand;

  logic [63:0] env_sum;
  logic [32:0] env_full;
  logic [31:0] env_next;
  logic [23:0] done_next;
  logic        last_next;

  logic in_acc;
  logic tick_go;
  logic out_free;

  dsg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dsg_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  dsg_sine_rom #(
    .Depth (SineTableDepth)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  // a tick produces a sample only inside an unfinished note
  assign tick_go    = in_acc && !restart_i && active_q && (done_q < cfg.sample_count);
  assign out_free   = !out_valid_q || out_ready_i;

  // index = phase[29:0] * depth >> 30, always below depth; odd quadrants mirror it
  assign k_idx    = prod[30 +: AddrW];
  assign rom_addr = phase_q[30] ? AddrW'(SineTableDepth) - k_idx : k_idx;

  // |sin| * amplitude rounded half up to Q.15; fits 17 bits
  assign amp_sum = prod[31:0] + 32'd16384;
  assign amp_mag = amp_sum[31:15];

  // magnitude * envelope rounded half up, then saturate by sign
  assign samp_mag = (prod + SampRound) >> SampShift;

  always_comb begin
    if (neg_q) begin
      samp_sat = (samp_mag > SampLimit) ? SampleBits'(SampLimit) : SampleBits'(samp_mag);
    end else begin
      samp_sat = (samp_mag > SampLimit - 64'd1) ? SampleBits'(SampLimit - 64'd1)
                                                : SampleBits'(samp_mag);
    end
  end

  assign samp_ext  = ResW'(samp_sat);
  assign samp_res  = neg_q ? (ResW'(0) - samp_ext) : samp_ext;
  assign peak_cand = (samp_ext > ResW'(16'hFFFF)) ? 16'hFFFF : samp_ext[15:0];

  // envelope * decay rounded half up to Q1.31, saturate to all ones
  assign env_sum   = prod + 64'h4000_0000;
  assign env_full  = env_sum[63:31];
  assign env_next  = env_full[32] ? 32'hFFFF_FFFF : env_full[31:0];
  assign done_next = done_q + 24'd1;
  assign last_next = (done_next >= cfg.sample_count);

  // operand select for the shared multiplier
  always_comb begin
    mul_en = (state_q != ST_UPD);
    mul_a  = {2'b00, phase_q[29:0]};
    mul_b  = 32'(SineTableDepth);
    case (state_q)
      ST_AMP: begin
        mul_a = 32'(rom_data);
        mul_b = 32'(cfg.amplitude);
      end
      ST_ENV: begin
        mul_a = 32'(amp_mag);
        mul_b = env_q;
      end
      ST_DEC: begin
        mul_a = env_q;
        mul_b = cfg.decay_factor;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (tick_go) state_d = ST_ADDR;
      ST_ADDR: state_d = ST_AMP;
      ST_AMP:  state_d = ST_ENV;
      ST_ENV:  state_d = ST_DEC;
      ST_DEC:  state_d = ST_UPD;
      ST_UPD:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      phase_q  <= '0;
      env_q    <= dsg_pkg::ENVELOPE_ONE;
      done_q   <= '0;
      peak_q   <= '0;
      active_q <= 1'b0;
      neg_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (restart_i) begin
              // new note: clear phase, envelope, count and peak
              phase_q  <= '0;
              env_q    <= dsg_pkg::ENVELOPE_ONE;
              done_q   <= '0;
              peak_q   <= '0;
              active_q <= (cfg.sample_count != 24'd0);
            end else if (active_q && !tick_go) begin
              // count was lowered under the samples already played: end quietly
              active_q <= 1'b0;
            end
          end
          neg_q <= phase_q[31];
        end
        ST_DEC: begin
          if (peak_cand > peak_q) begin
            peak_q <= peak_cand;
          end
        end
        ST_UPD: begin
          if (out_free) begin
            env_q   <= env_next;
            phase_q <= phase_q + cfg.phase_increment;
            done_q  <= done_next;
            if (last_next) begin
              active_q <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // sample held between the envelope product and the commit step
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DEC) begin
      res_sample_q <= samp_res[15:0];
    end
  end

  // output register: one beat waits here while the next tick is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_UPD) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_UPD) && out_free) begin
      out_sample_q <= res_sample_q;
      out_last_q   <= last_next;
      out_peak_q   <= peak_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign sample_o      = out_sample_q;
  assign last_sample_o = out_last_q;
  assign peak_level_o  = out_peak_q;

endmodule
